// ===== sv/sip_pkg.sv =====
// ----------------------------------------------------------------------------
// sip_pkg
// Shared types and constants for the segment intersection point pipeline.
// ----------------------------------------------------------------------------
package sip_pkg;

   localparam int FIELD_BITS       = 16;
   localparam int POINT_BITS       = 32;
   localparam int COORD_BITS_DEF   = 16;
   localparam int FRAC_BITS_DEF    = 16;

   typedef struct packed {
      logic signed [FIELD_BITS-1:0] a_start_x;
      logic signed [FIELD_BITS-1:0] a_start_y;
      logic signed [FIELD_BITS-1:0] a_end_x;
      logic signed [FIELD_BITS-1:0] a_end_y;
      logic signed [FIELD_BITS-1:0] b_start_x;
      logic signed [FIELD_BITS-1:0] b_start_y;
      logic signed [FIELD_BITS-1:0] b_end_x;
      logic signed [FIELD_BITS-1:0] b_end_y;
   } req_type;

   typedef struct packed {
      logic                         found;
      logic signed [POINT_BITS-1:0] point_x;
      logic signed [POINT_BITS-1:0] point_y;
   } rsp_type;

endpackage

// ===== sv/sip_div.sv =====
// ----------------------------------------------------------------------------
// sip_div
// Pipelined restoring divider, one quotient bit per stage, signed result.
// ----------------------------------------------------------------------------
module sip_div
   import sip_pkg::*;
#(
   parameter int MAG_BITS  = 53,
   parameter int DVS_BITS  = 34,
   parameter int QUOT_BITS = 32,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic                         in_neg,
   input  logic [MAG_BITS-1:0]          in_mag,
   input  logic [DVS_BITS-1:0]          in_dvs,
   output logic                         out_valid,
   output logic signed [POINT_BITS-1:0] out_quot
);

   localparam int NB = MAG_BITS + FRAC_BITS;

   logic                 v_ff   [QUOT_BITS+1];
   logic                 neg_ff [QUOT_BITS+1];
   logic [DVS_BITS-1:0]  rem_ff [QUOT_BITS+1];
   logic [QUOT_BITS-1:0] low_ff [QUOT_BITS+1];
   logic [QUOT_BITS-1:0] q_ff   [QUOT_BITS+1];
   logic [DVS_BITS-1:0]  dvs_ff [QUOT_BITS+1];

   logic [DVS_BITS-1:0]  rem_in [QUOT_BITS];
   logic [NB-1:0]        num;
   logic                 ge     [QUOT_BITS];
   logic [DVS_BITS:0]    trial  [QUOT_BITS];

   logic signed [QUOT_BITS:0]    sq;
   logic signed [QUOT_BITS+32:0] sq_wide;
   logic                         out_valid_ff;
   logic signed [POINT_BITS-1:0] out_quot_ff;

   assign num = NB'(in_mag) << FRAC_BITS;

   always_comb begin
      for (int k = 0; k < QUOT_BITS; k++) begin
         trial[k] = {rem_ff[k], low_ff[k][QUOT_BITS-1]};
         ge[k]    = trial[k] >= {1'b0, dvs_ff[k]};
         rem_in[k] = ge[k] ? DVS_BITS'(trial[k] - {1'b0, dvs_ff[k]}) : DVS_BITS'(trial[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= QUOT_BITS; k++) begin
            v_ff[k] <= 1'b0;
         end
      end else begin
         v_ff[0] <= in_valid;
         for (int k = 0; k < QUOT_BITS; k++) begin
            v_ff[k+1] <= v_ff[k];
         end
      end
      neg_ff[0] <= in_neg;
      dvs_ff[0] <= in_dvs;
      rem_ff[0] <= DVS_BITS'(num >> QUOT_BITS);
      low_ff[0] <= num[QUOT_BITS-1:0];
      q_ff[0]   <= '0;
      for (int k = 0; k < QUOT_BITS; k++) begin
         neg_ff[k+1] <= neg_ff[k];
         dvs_ff[k+1] <= dvs_ff[k];
         rem_ff[k+1] <= rem_in[k];
         low_ff[k+1] <= low_ff[k] << 1;
         q_ff[k+1]   <= {q_ff[k][QUOT_BITS-2:0], ge[k]};
      end
   end

   // apply sign, then keep the low bits of the sign-extended quotient
   assign sq      = neg_ff[QUOT_BITS] ? -$signed({1'b0, q_ff[QUOT_BITS]})
                                      :  $signed({1'b0, q_ff[QUOT_BITS]});
   assign sq_wide = {{32{sq[QUOT_BITS]}}, sq};

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= v_ff[QUOT_BITS];
      end
      out_quot_ff <= sq_wide[POINT_BITS-1:0];
   end

   assign out_valid = out_valid_ff;
   assign out_quot  = out_quot_ff;

endmodule

// ===== sv/segment_intersection_point.sv =====
// ----------------------------------------------------------------------------
// segment_intersection_point
// Intersection point of two integer segments, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one segment pair per clock and never stalls (busy stays low). Each
// result appears on rsp_data with rsp_strobe for one cycle, once it has passed
// the front stages, the divider and the output register; the divider resolves
// one quotient bit per stage. The receiver must take every result in the cycle
// it is shown.
module segment_intersection_point
   import sip_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int C   = COORD_BITS;
   localparam int DC  = C + 1;
   localparam int PW  = 2 * DC;
   localparam int DW  = PW + 1;
   localparam int NW  = C + DW + 2;
   localparam int QB  = C + FRAC_BITS;
   localparam int LAT = QB + 8;

   typedef struct packed {
      logic                         found;
      logic                         par;
      logic [POINT_BITS-1:0]        cx;
      logic [POINT_BITS-1:0]        cy;
   } side_type;

   function automatic logic signed [C-1:0] coord(input logic [FIELD_BITS-1:0] v);
      logic [C+FIELD_BITS-1:0] t;
      t = (C+FIELD_BITS)'(v);
      return signed'(t[C-1:0]);
   endfunction

   function automatic logic lex_less(input logic signed [C-1:0] x1, input logic signed [C-1:0] y1,
                                     input logic signed [C-1:0] x2, input logic signed [C-1:0] y2);
      return (x1 < x2) || ((x1 == x2) && (y1 < y2));
   endfunction

   function automatic logic [POINT_BITS-1:0] int_fix(input logic signed [C-1:0] v);
      logic [POINT_BITS-1:0] t;
      t = POINT_BITS'(v);
      return t << FRAC_BITS;
   endfunction

   // stage 1: coordinates and differences
   logic signed [C-1:0]  ax_in, ay_in, ex_in, ey_in, bx_in, by_in, fx_in, fy_in;
   logic                 v1_ff;
   logic signed [C-1:0]  ax1_ff, ay1_ff, ex1_ff, ey1_ff, bx1_ff, by1_ff, fx1_ff, fy1_ff;
   logic signed [DC-1:0] rx1_ff, ry1_ff, sx1_ff, sy1_ff, qx1_ff, qy1_ff, wx1_ff, wy1_ff;

   assign ax_in = coord(req_data.a_start_x);
   assign ay_in = coord(req_data.a_start_y);
   assign ex_in = coord(req_data.a_end_x);
   assign ey_in = coord(req_data.a_end_y);
   assign bx_in = coord(req_data.b_start_x);
   assign by_in = coord(req_data.b_start_y);
   assign fx_in = coord(req_data.b_end_x);
   assign fy_in = coord(req_data.b_end_y);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start && !busy;
      end
      ax1_ff <= ax_in; ay1_ff <= ay_in; ex1_ff <= ex_in; ey1_ff <= ey_in;
      bx1_ff <= bx_in; by1_ff <= by_in; fx1_ff <= fx_in; fy1_ff <= fy_in;
      rx1_ff <= DC'(ex_in) - DC'(ax_in);
      ry1_ff <= DC'(ey_in) - DC'(ay_in);
      sx1_ff <= DC'(fx_in) - DC'(bx_in);
      sy1_ff <= DC'(fy_in) - DC'(by_in);
      qx1_ff <= DC'(bx_in) - DC'(ax_in);
      qy1_ff <= DC'(by_in) - DC'(ay_in);
      wx1_ff <= DC'(fx_in) - DC'(ax_in);
      wy1_ff <= DC'(fy_in) - DC'(ay_in);
   end

   // stage 2: cross products and ordered endpoints
   logic                 v2_ff;
   logic signed [PW-1:0] p_rsy_ff, p_rys_ff, p_qsy_ff, p_qys_ff;
   logic signed [PW-1:0] p_qry_ff, p_qyr_ff, p_rwy_ff, p_ryw_ff;
   logic                 rnz2_ff, snz2_ff, qz2_ff;
   logic signed [C-1:0]  ax2_ff, ay2_ff;
   logic signed [DC-1:0] rx2_ff, ry2_ff;
   logic signed [C-1:0]  lax2_ff, lay2_ff, hax2_ff, hay2_ff;
   logic signed [C-1:0]  lbx2_ff, lby2_ff, hbx2_ff, hby2_ff;
   logic                 swa, swb;

   assign swa = lex_less(ex1_ff, ey1_ff, ax1_ff, ay1_ff);
   assign swb = lex_less(fx1_ff, fy1_ff, bx1_ff, by1_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      p_rsy_ff <= rx1_ff * sy1_ff;
      p_rys_ff <= ry1_ff * sx1_ff;
      p_qsy_ff <= qx1_ff * sy1_ff;
      p_qys_ff <= qy1_ff * sx1_ff;
      p_qry_ff <= qx1_ff * ry1_ff;
      p_qyr_ff <= qy1_ff * rx1_ff;
      p_rwy_ff <= rx1_ff * wy1_ff;
      p_ryw_ff <= ry1_ff * wx1_ff;
      rnz2_ff  <= (rx1_ff != 0) || (ry1_ff != 0);
      snz2_ff  <= (sx1_ff != 0) || (sy1_ff != 0);
      qz2_ff   <= (qx1_ff == 0) && (qy1_ff == 0);
      ax2_ff   <= ax1_ff; ay2_ff <= ay1_ff;
      rx2_ff   <= rx1_ff; ry2_ff <= ry1_ff;
      lax2_ff  <= swa ? ex1_ff : ax1_ff;
      lay2_ff  <= swa ? ey1_ff : ay1_ff;
      hax2_ff  <= swa ? ax1_ff : ex1_ff;
      hay2_ff  <= swa ? ay1_ff : ey1_ff;
      lbx2_ff  <= swb ? fx1_ff : bx1_ff;
      lby2_ff  <= swb ? fy1_ff : by1_ff;
      hbx2_ff  <= swb ? bx1_ff : fx1_ff;
      hby2_ff  <= swb ? by1_ff : fy1_ff;
   end

   // stage 3: determinant and numerators, sign normalized
   logic signed [DW-1:0] d_raw, tn_raw, un_raw, cf_raw;
   logic                 dneg, coll_in, ob, pa;
   logic                 v3_ff, par3_ff, coll3_ff;
   logic signed [DW-1:0] d3_ff, tn3_ff, un3_ff;
   logic signed [C-1:0]  ax3_ff, ay3_ff;
   logic signed [DC-1:0] rx3_ff, ry3_ff;
   logic signed [C-1:0]  ox3_ff, oy3_ff, px3_ff, py3_ff;

   assign d_raw  = DW'(p_rsy_ff) - DW'(p_rys_ff);
   assign tn_raw = DW'(p_qsy_ff) - DW'(p_qys_ff);
   assign un_raw = DW'(p_qry_ff) - DW'(p_qyr_ff);
   assign cf_raw = DW'(p_rwy_ff) - DW'(p_ryw_ff);
   assign dneg   = d_raw[DW-1];
   // un is the negated cross of r and q, tn the cross of s and a - b
   assign coll_in = rnz2_ff ? ((un_raw == 0) && (cf_raw == 0))
                  : snz2_ff ? (tn_raw == 0) : qz2_ff;
   assign ob = lex_less(lax2_ff, lay2_ff, lbx2_ff, lby2_ff);
   assign pa = lex_less(hax2_ff, hay2_ff, hbx2_ff, hby2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      par3_ff  <= d_raw == 0;
      coll3_ff <= coll_in;
      d3_ff    <= dneg ? -d_raw  : d_raw;
      tn3_ff   <= dneg ? -tn_raw : tn_raw;
      un3_ff   <= dneg ? -un_raw : un_raw;
      ax3_ff   <= ax2_ff; ay3_ff <= ay2_ff;
      rx3_ff   <= rx2_ff; ry3_ff <= ry2_ff;
      ox3_ff   <= ob ? lbx2_ff : lax2_ff;
      oy3_ff   <= ob ? lby2_ff : lay2_ff;
      px3_ff   <= pa ? hax2_ff : hbx2_ff;
      py3_ff   <= pa ? hay2_ff : hby2_ff;
   end

   // stage 4: range checks and numerator products
   logic                 inside_seg, found_in;
   logic                 v4_ff, found4_ff, par4_ff;
   logic signed [NW-1:0] mxa_ff, mxr_ff, mya_ff, myr_ff;
   logic signed [DW-1:0] d4_ff;
   logic [POINT_BITS-1:0] cx4_ff, cy4_ff;

   assign inside_seg = !((tn3_ff < 0) || (tn3_ff > d3_ff) || (un3_ff < 0) || (un3_ff > d3_ff));
   assign found_in   = par3_ff ? (coll3_ff && !lex_less(px3_ff, py3_ff, ox3_ff, oy3_ff))
                               : inside_seg;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
      found4_ff <= found_in;
      par4_ff   <= par3_ff;
      mxa_ff    <= ax3_ff * d3_ff;
      mxr_ff    <= rx3_ff * tn3_ff;
      mya_ff    <= ay3_ff * d3_ff;
      myr_ff    <= ry3_ff * tn3_ff;
      d4_ff     <= d3_ff;
      cx4_ff    <= int_fix(ox3_ff);
      cy4_ff    <= int_fix(oy3_ff);
   end

   // stage 5: numerator sums split into sign and magnitude
   logic signed [NW-1:0] numx, numy;
   logic                 v5_ff, negx5_ff, negy5_ff;
   logic [NW-1:0]        magx5_ff, magy5_ff;
   logic [DW-2:0]        dvs5_ff;
   side_type             side5_ff;

   assign numx = mxa_ff + mxr_ff;
   assign numy = mya_ff + myr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else begin
         v5_ff <= v4_ff;
      end
      negx5_ff <= numx[NW-1];
      negy5_ff <= numy[NW-1];
      magx5_ff <= numx[NW-1] ? NW'(-numx) : NW'(numx);
      magy5_ff <= numy[NW-1] ? NW'(-numy) : NW'(numy);
      dvs5_ff  <= d4_ff[DW-2:0];
      side5_ff <= '{found: found4_ff, par: par4_ff, cx: cx4_ff, cy: cy4_ff};
   end

   // divide by the determinant
   logic                         vx, vy;
   logic signed [POINT_BITS-1:0] qx, qy;

   sip_div #(
      .MAG_BITS (NW),
      .DVS_BITS (DW - 1),
      .QUOT_BITS(QB),
      .FRAC_BITS(FRAC_BITS)
   ) u_div_x (
      .clock    (clock),
      .reset    (reset),
      .in_valid (v5_ff),
      .in_neg   (negx5_ff),
      .in_mag   (magx5_ff),
      .in_dvs   (dvs5_ff),
      .out_valid(vx),
      .out_quot (qx)
   );

   sip_div #(
      .MAG_BITS (NW),
      .DVS_BITS (DW - 1),
      .QUOT_BITS(QB),
      .FRAC_BITS(FRAC_BITS)
   ) u_div_y (
      .clock    (clock),
      .reset    (reset),
      .in_valid (v5_ff),
      .in_neg   (negy5_ff),
      .in_mag   (magy5_ff),
      .in_dvs   (dvs5_ff),
      .out_valid(vy),
      .out_quot (qy)
   );

   // side data rides along with the divider
   side_type side_ff [QB+2];

   always_ff @(posedge clock) begin
      side_ff[0] <= side5_ff;
      for (int k = 0; k < QB + 1; k++) begin
         side_ff[k+1] <= side_ff[k];
      end
   end

   // output register
   logic    rsp_strobe_ff;
   rsp_type rsp_data_ff;
   rsp_type rsp_data_in;
   side_type side_out;

   assign side_out = side_ff[QB+1];

   always_comb begin
      rsp_data_in.found   = side_out.found;
      rsp_data_in.point_x = '0;
      rsp_data_in.point_y = '0;
      if (side_out.found) begin
         rsp_data_in.point_x = side_out.par ? signed'(side_out.cx) : qx;
         rsp_data_in.point_y = side_out.par ? signed'(side_out.cy) : qy;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= vx && vy;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign busy       = 1'b0;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_strobe)
      else $error("result beat missing at fixed latency");

   a_empty_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.found) |-> (rsp_data.point_x == 0 && rsp_data.point_y == 0))
      else $error("point not cleared when no intersection");

   a_div_aligned: assert property (@(posedge clock) disable iff (reset)
      vx == vy)
      else $error("divider lanes out of step");

endmodule

// ===== dv/sip_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sip_checker
// Watches the start and result channels of segment_intersection_point,
// predicts where each segment pair meets and compares every result beat.
// ----------------------------------------------------------------------------
module sip_checker
   import sip_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_data,
   input  logic    rsp_strobe,
   input  rsp_type rsp_data,
   output int      mismatches,
   output int      pending
);

   localparam int FRAC = FRAC_BITS_DEF;

   rsp_type meeting_q[$];

   initial mismatches = 0;
   initial pending = 0;

   function automatic longint cross2(longint ax, longint ay, longint bx, longint by);
      return ax * by - ay * bx;
   endfunction

   function automatic bit lex_lt(longint x1, longint y1, longint x2, longint y2);
      return x1 < x2 || (x1 == x2 && y1 < y2);
   endfunction

   function automatic rsp_type predict_meeting(req_type r);
      longint ax, ay, ex, ey, bx, by, fx, fy;
      longint rx, ry, sx, sy, qx, qy, d, tn, un;
      longint lax, lay, hax, hay, lbx, lby, hbx, hby, ox, oy, px, py;
      logic signed [127:0] wa, wd, wr, wt, nx, ny;
      bit collinear;
      rsp_type p;
      p = '0;
      ax = r.a_start_x; ay = r.a_start_y; ex = r.a_end_x; ey = r.a_end_y;
      bx = r.b_start_x; by = r.b_start_y; fx = r.b_end_x; fy = r.b_end_y;
      rx = ex - ax; ry = ey - ay; sx = fx - bx; sy = fy - by;
      qx = bx - ax; qy = by - ay;
      d = cross2(rx, ry, sx, sy);
      if (d != 0) begin
         tn = cross2(qx, qy, sx, sy);
         un = cross2(qx, qy, rx, ry);
         if (d < 0) begin
            d = -d; tn = -tn; un = -un;
         end
         if (tn < 0 || tn > d || un < 0 || un > d)
            return p;
         wd = d; wt = tn;
         wa = ax; wr = rx;
         nx = (wa * wd + wr * wt) <<< FRAC;
         wa = ay; wr = ry;
         ny = (wa * wd + wr * wt) <<< FRAC;
         nx = nx / wd;
         ny = ny / wd;
         p.found = 1'b1;
         p.point_x = nx[31:0];
         p.point_y = ny[31:0];
         return p;
      end
      if (rx != 0 || ry != 0)
         collinear = cross2(rx, ry, qx, qy) == 0 && cross2(rx, ry, fx - ax, fy - ay) == 0;
      else if (sx != 0 || sy != 0)
         collinear = cross2(sx, sy, ax - bx, ay - by) == 0;
      else
         collinear = qx == 0 && qy == 0;
      if (!collinear)
         return p;
      if (lex_lt(ex, ey, ax, ay)) begin
         lax = ex; lay = ey; hax = ax; hay = ay;
      end else begin
         lax = ax; lay = ay; hax = ex; hay = ey;
      end
      if (lex_lt(fx, fy, bx, by)) begin
         lbx = fx; lby = fy; hbx = bx; hby = by;
      end else begin
         lbx = bx; lby = by; hbx = fx; hby = fy;
      end
      if (lex_lt(lax, lay, lbx, lby)) begin
         ox = lbx; oy = lby;
      end else begin
         ox = lax; oy = lay;
      end
      if (lex_lt(hax, hay, hbx, hby)) begin
         px = hax; py = hay;
      end else begin
         px = hbx; py = hby;
      end
      if (lex_lt(px, py, ox, oy))
         return p;
      p.found = 1'b1;
      p.point_x = 32'(ox <<< FRAC);
      p.point_y = 32'(oy <<< FRAC);
      return p;
   endfunction

   task automatic report_mismatch(string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatches++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (start && !busy)
            meeting_q.push_back(predict_meeting(req_data));
         if (rsp_strobe) begin
            if (meeting_q.size() == 0) begin
               report_mismatch("result beat with nothing expected");
            end else begin
               want = meeting_q.pop_front();
               if (rsp_data.found !== want.found)
                  report_mismatch($sformatf("found %b, expected %b",
                                            rsp_data.found, want.found));
               if (rsp_data.point_x !== want.point_x)
                  report_mismatch($sformatf("point_x %h, expected %h",
                                            rsp_data.point_x, want.point_x));
               if (rsp_data.point_y !== want.point_y)
                  report_mismatch($sformatf("point_y %h, expected %h",
                                            rsp_data.point_y, want.point_y));
            end
         end
      end
      pending = meeting_q.size();
   end

endmodule

// ===== dv/segment_intersection_point_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_intersection_point_test
// Drives directed and random segment pairs into segment_intersection_point
// with random gaps; sip_checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module segment_intersection_point_test;
   import sip_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;
   int      mismatches;
   int      pending;
   int      cycles;
   int      idle_pct;

   segment_intersection_point uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   sip_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data),
      .mismatches(mismatches), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("segment_intersection_point test failed");
         $finish;
      end
   end

   function automatic req_type seg_pair(int ax, int ay, int ex, int ey,
                                        int bx, int by, int fx, int fy);
      req_type r;
      r.a_start_x = FIELD_BITS'(ax); r.a_start_y = FIELD_BITS'(ay);
      r.a_end_x   = FIELD_BITS'(ex); r.a_end_y   = FIELD_BITS'(ey);
      r.b_start_x = FIELD_BITS'(bx); r.b_start_y = FIELD_BITS'(by);
      r.b_end_x   = FIELD_BITS'(fx); r.b_end_y   = FIELD_BITS'(fy);
      return r;
   endfunction

   function automatic int small_val(int span);
      return $urandom_range(0, 2 * span) - span;
   endfunction

   function automatic req_type random_pair();
      req_type r;
      int x0, y0, dx, dy, t0, t1, t2, t3;
      x0 = small_val(30000); y0 = small_val(30000);
      dx = small_val(20);    dy = small_val(20);
      t0 = small_val(10); t1 = small_val(10); t2 = small_val(10); t3 = small_val(10);
      case ($urandom_range(0, 9))
         0, 1, 2: r = {$urandom, $urandom, $urandom, $urandom};
         3, 4:    r = seg_pair(small_val(20), small_val(20), small_val(20), small_val(20),
                               small_val(20), small_val(20), small_val(20), small_val(20));
         // points along one line, overlapping or not
         5, 6:    r = seg_pair(x0 + t0 * dx, y0 + t0 * dy, x0 + t1 * dx, y0 + t1 * dy,
                               x0 + t2 * dx, y0 + t2 * dy, x0 + t3 * dx, y0 + t3 * dy);
         // shared endpoint
         7:       r = seg_pair(x0, y0, x0 + small_val(500), y0 + small_val(500),
                               x0 + small_val(500), y0 + small_val(500), x0, y0);
         // degenerate first segment
         8:       r = seg_pair(x0 + t0 * dx, y0 + t0 * dy, x0 + t0 * dx, y0 + t0 * dy,
                               x0 + t1 * dx, y0 + t1 * dy,
                               x0 + t2 * dx + ($urandom_range(0, 3) == 0),
                               y0 + t2 * dy);
         default: r = seg_pair(x0, y0, x0 + dx * t0, y0 + dy * t0,
                               x0 + 1, y0, x0 + 1 + dx * t1, y0 + dy * t1);
      endcase
      return r;
   endfunction

   // holds start until the beat is taken at a rising edge
   task automatic send_pair(req_type r);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      @(negedge clock);
      while (busy) @(negedge clock);
      @(posedge clock);
   endtask

   initial begin
      req_type directed[$];
      start = 1'b0;
      req_data = '0;
      reset = 1'b1;
      idle_pct = 27;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      directed.push_back(seg_pair(0, 0, 10, 10, 0, 10, 10, 0));
      directed.push_back(seg_pair(0, 0, 3, 1, 0, 1, 2, 0));
      directed.push_back(seg_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
      directed.push_back(seg_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
      directed.push_back(seg_pair(-32768, -32768, -32768, -32768, -32768, -32768,
                                  -32768, -32768));
      directed.push_back(seg_pair(-32768, 32767, 32767, -32768, -32768, -32768,
                                  32767, 32767));
      directed.push_back(seg_pair(0, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(seg_pair(0, 0, 10, 0, 10, 0, 10, 10));
      directed.push_back(seg_pair(0, 0, 10, 0, 5, 0, 5, 8));
      directed.push_back(seg_pair(0, 0, 10, 0, 0, 1, 10, 1));
      directed.push_back(seg_pair(0, 0, 10, 0, 4, 0, 20, 0));
      directed.push_back(seg_pair(10, 0, 0, 0, 20, 0, 4, 0));
      directed.push_back(seg_pair(0, 0, 10, 0, 11, 0, 20, 0));
      directed.push_back(seg_pair(0, 0, 0, 10, 0, 10, 0, 20));
      directed.push_back(seg_pair(0, 5, 0, 9, 0, 0, 0, 20));
      directed.push_back(seg_pair(3, 3, 3, 3, 0, 0, 6, 6));
      directed.push_back(seg_pair(3, 4, 3, 4, 0, 0, 6, 6));
      directed.push_back(seg_pair(0, 0, 6, 6, 7, 7, 7, 7));
      directed.push_back(seg_pair(2, 2, 2, 2, 2, 2, 2, 2));
      directed.push_back(seg_pair(2, 2, 2, 2, 2, 3, 2, 3));
      directed.push_back(seg_pair(0, 0, 5, 0, 6, -1, 6, 1));
      directed.push_back(seg_pair(-7, 3, 9, -5, -1, -9, 4, 8));
      foreach (directed[i]) send_pair(directed[i]);

      start <= 1'b0;
      while (pending != 0) @(posedge clock);

      for (int n = 0; n < 950; n++) begin
         if (n == 320) idle_pct = 78;
         if (n == 640) idle_pct = 0;
         if (n == 500) begin
            start <= 1'b0;
            @(posedge clock);
            while (pending != 0) @(posedge clock);
         end
         send_pair(random_pair());
      end
      start <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (mismatches == 0)
         $display("segment_intersection_point test passed");
      else
         $display("segment_intersection_point test failed");
      $finish;
   end

endmodule
